/* rtl/core/lrs_pkg.sv */
// Shared constants and types for the labeled region statistics block.
`default_nettype none
package lrs_pkg;
    localparam int MaxWidth  = 4096;
    localparam int MaxHeight = 4096;
    localparam int CoordBits = 12;
    localparam int AreaBits  = 25;
    localparam logic [AreaBits-1:0] AreaCap = 25'(MaxWidth * MaxHeight);

    localparam logic [1:0] RegTarget  = 2'd0;
    localparam logic [1:0] RegWidth   = 2'd1;
    localparam logic [1:0] RegDivisor = 2'd2;

    // Divider operation request from the sequencer.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [24:0] divisor;
    } t_div_req;
endpackage
`default_nettype wire

/* rtl/core/lrs_divider.sv */
// Shared restoring divider, one quotient bit per cycle, 64 by 25 bits.
`default_nettype none
module lrs_divider (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lrs_pkg::t_div_req i_req,
    output logic                   o_done,
    output logic [63:0]            o_quot
);
    import lrs_pkg::*;

    logic [63:0] r_quot;
    logic [24:0] r_rem;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [24:0] r_div;
    logic [25:0] n_trial;
    logic        n_ge;

    always_comb begin
        n_trial = {r_rem, r_quot[63]};
        n_ge    = n_trial >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_quot <= i_req.dividend;
                r_div  <= i_req.divisor;
                r_rem  <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_rem  <= n_ge ? 25'(n_trial - {1'b0, r_div}) : n_trial[24:0];
                r_quot <= {r_quot[62:0], n_ge};
                r_cnt  <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_quot;
endmodule
`default_nettype wire

/* rtl/core/labeled_region_statistics.sv */
// Top level: pixel accumulation and the end-of-image statistics sequencer.
`default_nettype none
// Pixels are taken one per cycle while accumulating. Accepting the last pixel
// of an image starts a sequencer that holds o_in_stall high until the result
// is ready. If the previous image's result has not been taken yet, the
// sequencer first waits for that transfer. With a nonzero divisor it then
// runs four divides on one shared bit-serial divider (mean, variance,
// centroid x and y, plus a launch step for the variance divide), a 32-step
// square root, two multiply steps and one step each to start and finish. A
// zero divisor skips these, zeroes the fields and sets the status. The result
// then sits in the output registers and new pixels are accepted again.
module labeled_region_statistics (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic signed [15:0]  i_pixel_value,
    input  wire logic [15:0]         i_pixel_label,
    input  wire logic                i_last_pixel,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [24:0]              o_region_area,
    output logic signed [15:0]       o_region_mean,
    output logic [15:0]              o_region_std_dev,
    output logic [11:0]              o_centroid_x,
    output logic [11:0]              o_centroid_y,
    output logic                     o_stat_status,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [24:0]         i_cfg_data
);
    import lrs_pkg::*;

    typedef enum logic [3:0] {
        S_ACC, S_MEAN, S_MEAN_W, S_MUL1, S_MUL2, S_VAR_W, S_SQRT,
        S_CX_W, S_CY_W, S_OUT
    } t_state;

    t_state r_state;
    logic [15:0] r_target;
    logic [12:0] r_width;
    logic [24:0] r_divisor;
    logic [24:0] r_count;
    logic signed [39:0] r_vsum;
    logic [54:0] r_ssum;
    logic [35:0] r_xsum, r_ysum;
    logic [11:0] r_col, r_row;
    logic signed [16:0] r_mean;
    logic signed [63:0] r_prod;
    logic [63:0] r_rad;
    logic [31:0] r_root;
    logic [5:0]  r_step;
    t_div_req r_req;
    logic        w_done;
    logic [63:0] w_quot;
    logic        w_take;
    logic [12:0] w_eff;
    logic [63:0] w_vq;
    logic [63:0] w_mag;
    logic signed [42:0] w_cm;
    logic signed [63:0] w_pm;

    lrs_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(r_req),
        .o_done(w_done), .o_quot(w_quot)
    );

    assign o_in_stall  = (r_state != S_ACC);
    assign o_cfg_ready = (r_state == S_ACC);
    assign w_take      = i_in_valid && (r_state == S_ACC);
    assign w_eff = (r_width == 13'd0) ? 13'd1 :
                   (r_width > 13'(MaxWidth)) ? 13'(MaxWidth) : r_width;
    assign w_mag = r_vsum[39] ? -64'(r_vsum) : 64'(r_vsum);
    assign w_vq  = r_vsum[39] ? -w_quot : w_quot;
    assign w_cm  = $signed({1'b0, r_count}) * r_mean;
    assign w_pm  = $signed(r_prod[47:0]) * r_mean;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_ACC;
            r_target  <= '0;
            r_width   <= 13'd1;
            r_divisor <= 25'd1;
            r_count <= '0; r_vsum <= '0; r_ssum <= '0;
            r_xsum  <= '0; r_ysum <= '0; r_col  <= '0; r_row <= '0;
            r_req.start <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_req.start <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    RegTarget:  r_target  <= i_cfg_data[15:0];
                    RegWidth:   r_width   <= i_cfg_data[12:0];
                    RegDivisor: r_divisor <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_ACC: begin
                    if (w_take) begin
                        if (i_pixel_label == r_target && r_count < AreaCap) begin
                            r_count <= r_count + 25'd1;
                            r_vsum  <= r_vsum + 40'(i_pixel_value);
                            r_ssum  <= r_ssum +
                                       55'(32'(i_pixel_value) * 32'(i_pixel_value));
                            r_xsum  <= r_xsum + 36'(r_col);
                            r_ysum  <= r_ysum + 36'(r_row);
                        end
                        if (13'(r_col) + 13'd1 >= w_eff) begin
                            r_col <= '0;
                            r_row <= (r_row == 12'(MaxHeight - 1)) ? '0 : r_row + 12'd1;
                        end else begin
                            r_col <= r_col + 12'd1;
                        end
                        if (i_last_pixel) begin
                            r_state <= S_MEAN;
                        end
                    end
                end
                S_MEAN: begin
                    // The output registers still hold the previous result until
                    // its transfer.
                    if (o_out_valid) begin
                        r_state <= S_MEAN;
                    end else if (r_divisor == '0) begin
                        o_region_area <= '0; o_region_mean <= '0;
                        o_region_std_dev <= '0; o_centroid_x <= '0;
                        o_centroid_y <= '0; o_stat_status <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_req.start    <= 1'b1;
                        r_req.dividend <= w_mag;
                        r_req.divisor  <= r_divisor;
                        r_state <= S_MEAN_W;
                    end
                end
                S_MEAN_W: begin
                    if (w_done) begin
                        if ($signed(w_vq) > 64'sd32767) r_mean <= 17'sd32767;
                        else if ($signed(w_vq) < -64'sd32768) r_mean <= -17'sd32768;
                        else r_mean <= 17'(w_vq);
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    // count*m - 2*sum, then times m.
                    r_prod  <= 64'(w_cm) - (64'(r_vsum) <<< 1);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_prod <= 64'(r_ssum) + w_pm;
                    r_step <= 6'd1;
                    r_state <= S_VAR_W;
                end
                S_VAR_W: begin
                    if (r_step == 6'd1) begin
                        r_req.start    <= 1'b1;
                        r_req.dividend <= r_prod[63] ? '0 : r_prod;
                        r_req.divisor  <= r_divisor;
                        r_step <= '0;
                    end else if (w_done) begin
                        r_rad  <= w_quot;
                        r_prod <= '0;
                        r_root <= '0;
                        r_step <= '0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    // r_prod holds the partial remainder; two radicand bits per
                    // step are tried against 4*root+1.
                    if ({r_prod[61:0], r_rad[63:62]} >= 64'({r_root, 2'b01})) begin
                        r_prod <= {r_prod[61:0], r_rad[63:62]} - 64'({r_root, 2'b01});
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_prod <= {r_prod[61:0], r_rad[63:62]};
                        r_root <= {r_root[30:0], 1'b0};
                    end
                    r_rad  <= {r_rad[61:0], 2'b00};
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'd31) begin
                        r_req.start    <= 1'b1;
                        r_req.dividend <= 64'(r_xsum);
                        r_req.divisor  <= r_divisor;
                        r_state <= S_CX_W;
                    end
                end
                S_CX_W: begin
                    if (w_done) begin
                        o_centroid_x <= (w_quot > 64'd4095) ? 12'd4095 : w_quot[11:0];
                        r_req.start    <= 1'b1;
                        r_req.dividend <= 64'(r_ysum);
                        r_req.divisor  <= r_divisor;
                        r_state <= S_CY_W;
                    end
                end
                S_CY_W: begin
                    if (w_done) begin
                        o_centroid_y <= (w_quot > 64'd4095) ? 12'd4095 : w_quot[11:0];
                        o_region_area <= r_count;
                        o_region_mean <= r_mean[15:0];
                        o_region_std_dev <= (r_root > 32'd65535) ? 16'hFFFF : r_root[15:0];
                        o_stat_status <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!(o_out_valid && i_out_stall)) begin
                        o_out_valid <= 1'b1;
                        r_count <= '0; r_vsum <= '0; r_ssum <= '0;
                        r_xsum  <= '0; r_ysum <= '0; r_col <= '0; r_row <= '0;
                        r_state <= S_ACC;
                    end
                end
                default: r_state <= S_ACC;
            endcase
            if (o_out_valid && !i_out_stall && r_state != S_OUT) o_out_valid <= 1'b0;
        end
    end

    a_no_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_ACC) |-> !o_cfg_ready) else $error("cfg ready while busy");
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req.start |-> (r_state != S_ACC)) else $error("divide outside sequence");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stat_status) |-> (o_region_area == '0))
        else $error("error result not cleared");
endmodule
`default_nettype wire

/* test/labeled_region_statistics_tb.sv */
// Self-checking testbench for labeled_region_statistics: directed and random images.
`default_nettype none
module labeled_region_statistics_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lrs_pkg::*;

    localparam logic [1:0] RegUnused = 2'd3;
    localparam int CycleLimit = 600000;

    typedef struct {
        logic signed [15:0] value;
        logic [15:0]        label;
        logic               last;
    } t_pixel;

    typedef struct {
        logic [24:0]        area;
        logic signed [15:0] mean;
        logic [15:0]        std_dev;
        logic [11:0]        cx;
        logic [11:0]        cy;
        logic               status;
    } t_stats;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [15:0] i_pixel_value = '0;
    logic [15:0] i_pixel_label = '0;
    logic i_last_pixel = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [24:0] o_region_area;
    logic signed [15:0] o_region_mean;
    logic [15:0] o_region_std_dev;
    logic [11:0] o_centroid_x;
    logic [11:0] o_centroid_y;
    logic o_stat_status;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [24:0] i_cfg_data = '0;

    labeled_region_statistics u_top (.*);

    always #10 i_clk = ~i_clk;

    // Configuration and accumulator copies used for prediction.
    logic [15:0] cur_target;
    logic [12:0] cur_width;
    logic [24:0] cur_divisor;
    longint unsigned match_cnt, sq_sum, xsum, ysum;
    longint signed val_sum;
    int unsigned col, row;

    t_pixel pixel_q[$];
    t_stats stats_q[$];
    int idle_pct = 0, stall_pct = 0, errors = 0;
    int unsigned cycles = 0, hold_cnt = 0;
    logic hold_req = 1'b0, took_pixel = 1'b0;

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r = 0, t;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic void clear_image();
        match_cnt = 0; val_sum = 0; sq_sum = 0; xsum = 0; ysum = 0; col = 0; row = 0;
    endfunction

    // Accumulate one accepted pixel; on the last pixel queue the statistics.
    function automatic void accumulate_pixel(t_pixel p);
        int unsigned w;
        longint signed m, ss, d;
        longint unsigned sd, cx, cy;
        t_stats s;
        w = (cur_width == 0) ? 1 : (cur_width > MaxWidth) ? MaxWidth : cur_width;
        if (p.label == cur_target && match_cnt < MaxWidth * MaxHeight) begin
            match_cnt += 1;
            val_sum += p.value;
            sq_sum += longint'(p.value) * longint'(p.value);
            xsum += col;
            ysum += row;
        end
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= MaxHeight) row = 0;
        end
        if (!p.last) return;
        s = '{default: '0};
        if (cur_divisor == 0) begin
            s.status = 1'b1;
        end else begin
            d = cur_divisor;
            m = val_sum / d;
            if (m > 32767) m = 32767;
            if (m < -32768) m = -32768;
            ss = longint'(sq_sum) - 2 * m * val_sum + longint'(match_cnt) * m * m;
            if (ss < 0) ss = 0;
            sd = floor_sqrt(longint'(ss) / d);
            cx = xsum / cur_divisor;
            cy = ysum / cur_divisor;
            s.area = match_cnt[24:0];
            s.mean = m[15:0];
            s.std_dev = (sd > 65535) ? 16'hFFFF : sd[15:0];
            s.cx = (cx > 4095) ? 12'hFFF : cx[11:0];
            s.cy = (cy > 4095) ? 12'hFFF : cy[11:0];
        end
        stats_q.push_back(s);
        clear_image();
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", field, got, want, cycles);
        errors++;
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("Timeout at cycle %0d", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // Input side: prediction on the accepting edge, new payload at the falling edge.
    always @(posedge i_clk) begin
        took_pixel = i_in_valid && !o_in_stall;
        if (took_pixel)
            accumulate_pixel('{i_pixel_value, i_pixel_label, i_last_pixel});
    end

    always @(negedge i_clk) begin
        t_pixel p;
        if (!i_in_valid || took_pixel) begin
            if (pixel_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                p = pixel_q.pop_front();
                i_in_valid <= 1'b1;
                i_pixel_value <= p.value;
                i_pixel_label <= p.label;
                i_last_pixel <= p.last;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output side: random stall, plus a long hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = 2500;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_stats e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (stats_q.size() == 0) begin
                report("unexpected result transfer", 1, 0);
            end else begin
                e = stats_q.pop_front();
                if (o_region_area !== e.area) report("area", o_region_area, e.area);
                if (o_region_mean !== e.mean) report("mean", o_region_mean, e.mean);
                if (o_region_std_dev !== e.std_dev)
                    report("std_dev", o_region_std_dev, e.std_dev);
                if (o_centroid_x !== e.cx) report("centroid_x", o_centroid_x, e.cx);
                if (o_centroid_y !== e.cy) report("centroid_y", o_centroid_y, e.cy);
                if (o_stat_status !== e.status) report("status", o_stat_status, e.status);
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [24:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            RegTarget:  cur_target = data[15:0];
            RegWidth:   cur_width = data[12:0];
            RegDivisor: cur_divisor = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pixel_q.size() > 0 || i_in_valid || stats_q.size() > 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic add_pixel(logic signed [15:0] v, logic [15:0] lbl, logic last);
        pixel_q.push_back('{v, lbl, last});
    endtask

    function automatic logic signed [15:0] rand_value();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // One image of random content; most pixels carry the target label.
    task automatic add_image(int len, int match_pct);
        for (int k = 0; k < len; k++)
            add_pixel(rand_value(),
                      ($urandom_range(99) < match_pct) ? cur_target :
                                                         16'($urandom_range(16'hFFFF)),
                      k == len - 1);
    endtask

    task automatic random_config();
        case ($urandom_range(3))
            0: write_reg(RegTarget, 25'($urandom_range(25'h1FFFFFF)));
            default: write_reg(RegTarget, 25'($urandom_range(3)));
        endcase
        case ($urandom_range(4))
            0: write_reg(RegWidth, 25'($urandom_range(13'h1FFF)));
            1: write_reg(RegWidth, 25'(MaxWidth));
            default: write_reg(RegWidth, 25'($urandom_range(8)));
        endcase
        case ($urandom_range(7))
            0: write_reg(RegDivisor, 25'd0);
            1: write_reg(RegDivisor, 25'($urandom_range(25'h1FFFFFF)));
            2: write_reg(RegDivisor, 25'd16777216);
            3: write_reg(RegDivisor, 25'd1);
            default: write_reg(RegDivisor, 25'($urandom_range(1, 24)));
        endcase
    endtask

    initial begin
        int sent;
        cur_target = 0;
        cur_width = 1;
        cur_divisor = 1;
        clear_image();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration first, then extremes of every field.
        add_pixel(16'sh7FFF, 16'd0, 1'b0);
        add_pixel(16'sh8000, 16'd0, 1'b0);
        add_pixel(16'sh0000, 16'hFFFF, 1'b0);
        add_pixel(16'sh7FFF, 16'd0, 1'b1);
        wait_idle();
        write_reg(RegWidth, 25'd0);
        write_reg(RegTarget, 25'h1FFFFFF);
        write_reg(RegUnused, 25'h1FFFFFF);
        write_reg(RegDivisor, 25'd0);
        add_pixel(16'sh1234, 16'hFFFF, 1'b0);
        add_pixel(16'sh8000, 16'hFFFF, 1'b1);
        wait_idle();
        write_reg(RegDivisor, 25'h1FFFFFF);
        write_reg(RegWidth, 25'h1FFF);
        add_pixel(16'sh7FFF, 16'hFFFF, 1'b0);
        add_pixel(16'sh8000, 16'h0000, 1'b0);
        add_pixel(16'sh0100, 16'hFFFF, 1'b1);
        wait_idle();
        write_reg(RegDivisor, 25'd2);
        write_reg(RegWidth, 25'd3);
        for (int k = 0; k < 9; k++) add_pixel(16'sh8000, 16'hFFFF, k == 8);
        wait_idle();

        // Long receiver hold-off while several images keep coming.
        hold_req = 1'b1;
        for (int k = 0; k < 3; k++) add_image(6, 80);
        wait_idle();

        sent = 0;
        for (int ph = 0; sent < 450; ph++) begin
            random_config();
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 59; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 59; end
                default: begin idle_pct = 8; stall_pct = 8; end
            endcase
            for (int k = 0; k < 4; k++) begin
                int len;
                len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
                add_image(len, 75);
                sent += len;
            end
            wait_idle();
        end

        idle_pct = 0;
        stall_pct = 0;
        wait_idle();
        repeat (400) @(posedge i_clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
rtl/core/lrs_pkg.sv
rtl/core/lrs_divider.sv
rtl/core/labeled_region_statistics.sv
test/labeled_region_statistics_tb.sv
